### hdl/dccm_pkg.sv
// ---------------------------------------------------------------------------
// DRAM column command monitor package
// Command, pair class and statistic codes, reset values and the stage payload
// ---------------------------------------------------------------------------
package dccm_pkg;

   localparam int unsigned CYCLE_W   = 64;
   localparam int unsigned TCCD_W    = 8;
   localparam int unsigned STAT_NUM  = 18;
   localparam int unsigned MIN_NUM   = 3;

   localparam logic [TCCD_W-1:0] TCCD_SHORT_RESET = 8'd2;
   localparam logic [TCCD_W-1:0] TCCD_LONG_RESET  = 8'd4;

   // request kinds
   localparam logic REQ_COMMAND = 1'b0;
   localparam logic REQ_COUNTER = 1'b1;

   // csr indexes
   localparam logic CSR_TCCD_SHORT = 1'b0;
   localparam logic CSR_TCCD_LONG  = 1'b1;

   typedef enum logic [2:0] {
      CMD_READ,
      CMD_WRITE,
      CMD_ACTIVATE,
      CMD_PRECHARGE,
      CMD_REFRESH_BANK,
      CMD_REFRESH_ALL,
      CMD_OTHER
   } cmd_type;

   typedef enum logic [1:0] {
      CLS_NONE,
      CLS_SAME_GROUP,
      CLS_OTHER_GROUP,
      CLS_CROSS_CHANNEL
   } class_type;

   // statistic selects seen on the counter index field
   localparam logic [4:0] CIDX_READS       = 5'd0;
   localparam logic [4:0] CIDX_WRITES      = 5'd1;
   localparam logic [4:0] CIDX_ACTIVATES   = 5'd2;
   localparam logic [4:0] CIDX_PRECHARGES  = 5'd3;
   localparam logic [4:0] CIDX_REF_BANK    = 5'd4;
   localparam logic [4:0] CIDX_REF_ALL     = 5'd5;
   localparam logic [4:0] CIDX_FIRST_READ  = 5'd6;
   localparam logic [4:0] CIDX_LAST_READ   = 5'd7;
   localparam logic [4:0] CIDX_WINDOW      = 5'd8;
   localparam logic [4:0] CIDX_L_PAIRS     = 5'd9;
   localparam logic [4:0] CIDX_L_SUM       = 5'd10;
   localparam logic [4:0] CIDX_L_MIN       = 5'd11;
   localparam logic [4:0] CIDX_L_VIOL      = 5'd12;
   localparam logic [4:0] CIDX_S_PAIRS     = 5'd13;
   localparam logic [4:0] CIDX_S_SUM       = 5'd14;
   localparam logic [4:0] CIDX_S_MIN       = 5'd15;
   localparam logic [4:0] CIDX_S_VIOL      = 5'd16;
   localparam logic [4:0] CIDX_X_PAIRS     = 5'd17;
   localparam logic [4:0] CIDX_X_SUM       = 5'd18;
   localparam logic [4:0] CIDX_X_MIN       = 5'd19;
   localparam logic [4:0] CIDX_SW_COUNT    = 5'd20;
   localparam logic [4:0] CIDX_SW_SUM      = 5'd21;
   localparam logic [4:0] CIDX_COL_PAIRS   = 5'd22;
   localparam logic [4:0] CIDX_COL_SUM     = 5'd23;

   // slots of the counter bank
   localparam int unsigned SLOT_RD        = 0;
   localparam int unsigned SLOT_WR        = 1;
   localparam int unsigned SLOT_ACT       = 2;
   localparam int unsigned SLOT_PRE       = 3;
   localparam int unsigned SLOT_REFPB     = 4;
   localparam int unsigned SLOT_REFAB     = 5;
   localparam int unsigned SLOT_L_PAIRS   = 6;
   localparam int unsigned SLOT_L_SUM     = 7;
   localparam int unsigned SLOT_L_VIOL    = 8;
   localparam int unsigned SLOT_S_PAIRS   = 9;
   localparam int unsigned SLOT_S_SUM     = 10;
   localparam int unsigned SLOT_S_VIOL    = 11;
   localparam int unsigned SLOT_X_PAIRS   = 12;
   localparam int unsigned SLOT_X_SUM     = 13;
   localparam int unsigned SLOT_SW_COUNT  = 14;
   localparam int unsigned SLOT_SW_SUM    = 15;
   localparam int unsigned SLOT_COL_PAIRS = 16;
   localparam int unsigned SLOT_COL_SUM   = 17;

   localparam int unsigned MIN_L = 0;
   localparam int unsigned MIN_S = 1;
   localparam int unsigned MIN_X = 2;

   typedef struct packed {
      logic               is_counter;
      logic [2:0]         command;
      logic [4:0]         counter_index;
      logic [CYCLE_W-1:0] gap;
      class_type          pair_class;
      logic               col_valid;
      logic               dir_switch;
      logic               have_read;
      logic [CYCLE_W-1:0] first_read;
      logic [CYCLE_W-1:0] last_read;
   } stage_type;

endpackage

### hdl/dram_column_command_monitor_top.sv
// ---------------------------------------------------------------------------
// DRAM column command monitor
// Counts issued commands, measures column gaps and classes read pairs
// ---------------------------------------------------------------------------
// path: an accepted request beat passes the input stage, second stage and response
//   registers; throughput: one beat per cycle unless rsp_stall holds the pipeline;
//   tracking registers update in the first stage, counters and minima in the
//   second, so every step is one subtract or one add and compare
// reset: synchronous; counters clear, minima go to all ones, tCCD short 2 and
//   long 4, pipeline empties
module dram_column_command_monitor_top
   import dccm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [2:0]         req_command,
   input  logic [CYCLE_W-1:0] req_issue_cycle,
   input  logic [2:0]         req_pseudo_channel,
   input  logic [3:0]         req_bank_group,
   input  logic [4:0]         req_counter_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CYCLE_W-1:0] rsp_counter_value,
   output logic [1:0]         rsp_pair_class,
   output logic [CYCLE_W-1:0] rsp_column_gap,
   output logic               rsp_timing_violation,
   output logic               rsp_direction_switch,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [TCCD_W-1:0]  csr_data
);

   // handshake
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic out_ready, s2_ready, s1_ready, s1_fire, s2_fire;

   // configuration
   logic [TCCD_W-1:0] tccd_short_ff, tccd_long_ff;

   // input stage beat
   logic               s1_type_ff;
   logic [2:0]         s1_command_ff;
   logic [CYCLE_W-1:0] s1_cycle_ff;
   logic [2:0]         s1_channel_ff;
   logic [3:0]         s1_group_ff;
   logic [4:0]         s1_index_ff;

   // tracking state
   logic               have_read_ff, have_read_in;
   logic               have_col_ff, have_col_in;
   logic               last_col_read_ff, last_col_read_in;
   logic [CYCLE_W-1:0] first_read_ff, first_read_in;
   logic [CYCLE_W-1:0] last_read_ff, last_read_in;
   logic [CYCLE_W-1:0] last_col_ff, last_col_in;
   logic [2:0]         last_channel_ff, last_channel_in;
   logic [3:0]         last_group_ff, last_group_in;

   stage_type s2_ff, s2_in;

   // statistics
   logic [CYCLE_W-1:0] stat_ff [STAT_NUM];
   logic [CYCLE_W-1:0] stat_in [STAT_NUM];
   logic [CYCLE_W-1:0] min_ff [MIN_NUM];
   logic [CYCLE_W-1:0] min_in [MIN_NUM];

   // response payload
   logic [CYCLE_W-1:0] counter_ff, counter_in;
   logic [1:0]         class_ff;
   logic [CYCLE_W-1:0] gap_ff, gap_in;
   logic               viol_ff, viol_in;
   logic               switch_ff, switch_in;

   logic               s1_is_read, s1_is_write, s1_is_col;
   logic [CYCLE_W-1:0] s1_gap;
   logic               s2_is_cmd;
   logic [CYCLE_W-1:0] window;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign s1_fire   = s1_valid_ff && s2_ready;
   assign s2_fire   = s2_valid_ff && out_ready;
   assign req_stall = !s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tccd_short_ff <= TCCD_SHORT_RESET;
         tccd_long_ff  <= TCCD_LONG_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TCCD_SHORT: tccd_short_ff <= csr_data;
            CSR_TCCD_LONG:  tccd_long_ff  <= csr_data;
            default:        tccd_long_ff  <= tccd_long_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_ready) begin
         s1_type_ff    <= req_type;
         s1_command_ff <= req_command;
         s1_cycle_ff   <= req_issue_cycle;
         s1_channel_ff <= req_pseudo_channel;
         s1_group_ff   <= req_bank_group;
         s1_index_ff   <= req_counter_index;
      end
   end

   // first stage: gap, pair class and tracking update
   assign s1_is_read  = (s1_type_ff == REQ_COMMAND) && (s1_command_ff == CMD_READ);
   assign s1_is_write = (s1_type_ff == REQ_COMMAND) && (s1_command_ff == CMD_WRITE);
   assign s1_is_col   = s1_is_read || s1_is_write;
   // last column was a read, so last read and last column cycles agree on a pair
   assign s1_gap      = s1_cycle_ff - last_col_ff;

   always_comb begin
      have_read_in     = have_read_ff;
      have_col_in      = have_col_ff;
      last_col_read_in = last_col_read_ff;
      first_read_in    = first_read_ff;
      last_read_in     = last_read_ff;
      last_col_in      = last_col_ff;
      last_channel_in  = last_channel_ff;
      last_group_in    = last_group_ff;

      s2_in.is_counter    = s1_type_ff;
      s2_in.command       = s1_command_ff;
      s2_in.counter_index = s1_index_ff;
      s2_in.gap           = s1_gap;
      s2_in.pair_class    = CLS_NONE;
      s2_in.col_valid     = s1_is_col && have_col_ff;
      s2_in.dir_switch    = s1_is_col && have_col_ff && (last_col_read_ff != s1_is_read);
      s2_in.have_read     = have_read_ff;
      s2_in.first_read    = first_read_ff;
      s2_in.last_read     = last_read_ff;

      if (s1_is_read && have_read_ff && have_col_ff && last_col_read_ff) begin
         if (s1_channel_ff != last_channel_ff) begin
            s2_in.pair_class = CLS_CROSS_CHANNEL;
         end else if (s1_group_ff == last_group_ff) begin
            s2_in.pair_class = CLS_SAME_GROUP;
         end else begin
            s2_in.pair_class = CLS_OTHER_GROUP;
         end
      end

      if (s1_is_read) begin
         if (!have_read_ff) begin
            first_read_in = s1_cycle_ff;
         end
         have_read_in    = 1'b1;
         last_read_in    = s1_cycle_ff;
         last_channel_in = s1_channel_ff;
         last_group_in   = s1_group_ff;
      end
      if (s1_is_col) begin
         have_col_in      = 1'b1;
         last_col_read_in = s1_is_read;
         last_col_in      = s1_cycle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_read_ff     <= 1'b0;
         have_col_ff      <= 1'b0;
         last_col_read_ff <= 1'b0;
         first_read_ff    <= '0;
         last_read_ff     <= '0;
         last_col_ff      <= '0;
         last_channel_ff  <= '0;
         last_group_ff    <= '0;
      end else if (s1_fire) begin
         have_read_ff     <= have_read_in;
         have_col_ff      <= have_col_in;
         last_col_read_ff <= last_col_read_in;
         first_read_ff    <= first_read_in;
         last_read_ff     <= last_read_in;
         last_col_ff      <= last_col_in;
         last_channel_ff  <= last_channel_in;
         last_group_ff    <= last_group_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         s2_ff <= s2_in;
      end
   end

   // second stage: accumulate and select the response
   assign s2_is_cmd = (s2_ff.is_counter == REQ_COMMAND);
   assign window    = s2_ff.last_read - s2_ff.first_read + 64'd1;

   always_comb begin
      for (int i = 0; i < STAT_NUM; i++) begin
         stat_in[i] = stat_ff[i];
      end
      for (int i = 0; i < MIN_NUM; i++) begin
         min_in[i] = min_ff[i];
      end
      viol_in = 1'b0;

      if (s2_is_cmd) begin
         case (s2_ff.command)
            CMD_READ:         stat_in[SLOT_RD]    = stat_ff[SLOT_RD] + 64'd1;
            CMD_WRITE:        stat_in[SLOT_WR]    = stat_ff[SLOT_WR] + 64'd1;
            CMD_ACTIVATE:     stat_in[SLOT_ACT]   = stat_ff[SLOT_ACT] + 64'd1;
            CMD_PRECHARGE:    stat_in[SLOT_PRE]   = stat_ff[SLOT_PRE] + 64'd1;
            CMD_REFRESH_BANK: stat_in[SLOT_REFPB] = stat_ff[SLOT_REFPB] + 64'd1;
            CMD_REFRESH_ALL:  stat_in[SLOT_REFAB] = stat_ff[SLOT_REFAB] + 64'd1;
            default:          stat_in[SLOT_RD]    = stat_ff[SLOT_RD];
         endcase

         case (s2_ff.pair_class)
            CLS_SAME_GROUP: begin
               stat_in[SLOT_L_PAIRS] = stat_ff[SLOT_L_PAIRS] + 64'd1;
               stat_in[SLOT_L_SUM]   = stat_ff[SLOT_L_SUM] + s2_ff.gap;
               if (s2_ff.gap < min_ff[MIN_L]) begin
                  min_in[MIN_L] = s2_ff.gap;
               end
               if (s2_ff.gap < {{(CYCLE_W-TCCD_W){1'b0}}, tccd_long_ff}) begin
                  viol_in              = 1'b1;
                  stat_in[SLOT_L_VIOL] = stat_ff[SLOT_L_VIOL] + 64'd1;
               end
            end
            CLS_OTHER_GROUP: begin
               stat_in[SLOT_S_PAIRS] = stat_ff[SLOT_S_PAIRS] + 64'd1;
               stat_in[SLOT_S_SUM]   = stat_ff[SLOT_S_SUM] + s2_ff.gap;
               if (s2_ff.gap < min_ff[MIN_S]) begin
                  min_in[MIN_S] = s2_ff.gap;
               end
               if (s2_ff.gap < {{(CYCLE_W-TCCD_W){1'b0}}, tccd_short_ff}) begin
                  viol_in              = 1'b1;
                  stat_in[SLOT_S_VIOL] = stat_ff[SLOT_S_VIOL] + 64'd1;
               end
            end
            CLS_CROSS_CHANNEL: begin
               stat_in[SLOT_X_PAIRS] = stat_ff[SLOT_X_PAIRS] + 64'd1;
               stat_in[SLOT_X_SUM]   = stat_ff[SLOT_X_SUM] + s2_ff.gap;
               if (s2_ff.gap < min_ff[MIN_X]) begin
                  min_in[MIN_X] = s2_ff.gap;
               end
            end
            default: viol_in = 1'b0;
         endcase

         if (s2_ff.col_valid) begin
            stat_in[SLOT_COL_PAIRS] = stat_ff[SLOT_COL_PAIRS] + 64'd1;
            stat_in[SLOT_COL_SUM]   = stat_ff[SLOT_COL_SUM] + s2_ff.gap;
         end
         if (s2_ff.dir_switch) begin
            stat_in[SLOT_SW_COUNT] = stat_ff[SLOT_SW_COUNT] + 64'd1;
            stat_in[SLOT_SW_SUM]   = stat_ff[SLOT_SW_SUM] + s2_ff.gap;
         end
      end
   end

   // counter read select; unset minima show as zero
   always_comb begin
      counter_in = '0;
      if (!s2_is_cmd) begin
         case (s2_ff.counter_index)
            CIDX_READS:      counter_in = stat_ff[SLOT_RD];
            CIDX_WRITES:     counter_in = stat_ff[SLOT_WR];
            CIDX_ACTIVATES:  counter_in = stat_ff[SLOT_ACT];
            CIDX_PRECHARGES: counter_in = stat_ff[SLOT_PRE];
            CIDX_REF_BANK:   counter_in = stat_ff[SLOT_REFPB];
            CIDX_REF_ALL:    counter_in = stat_ff[SLOT_REFAB];
            CIDX_FIRST_READ: counter_in = s2_ff.have_read ? s2_ff.first_read : '0;
            CIDX_LAST_READ:  counter_in = s2_ff.have_read ? s2_ff.last_read : '0;
            CIDX_WINDOW:     counter_in = s2_ff.have_read ? window : '0;
            CIDX_L_PAIRS:    counter_in = stat_ff[SLOT_L_PAIRS];
            CIDX_L_SUM:      counter_in = stat_ff[SLOT_L_SUM];
            CIDX_L_MIN:      counter_in = (&min_ff[MIN_L]) ? '0 : min_ff[MIN_L];
            CIDX_L_VIOL:     counter_in = stat_ff[SLOT_L_VIOL];
            CIDX_S_PAIRS:    counter_in = stat_ff[SLOT_S_PAIRS];
            CIDX_S_SUM:      counter_in = stat_ff[SLOT_S_SUM];
            CIDX_S_MIN:      counter_in = (&min_ff[MIN_S]) ? '0 : min_ff[MIN_S];
            CIDX_S_VIOL:     counter_in = stat_ff[SLOT_S_VIOL];
            CIDX_X_PAIRS:    counter_in = stat_ff[SLOT_X_PAIRS];
            CIDX_X_SUM:      counter_in = stat_ff[SLOT_X_SUM];
            CIDX_X_MIN:      counter_in = (&min_ff[MIN_X]) ? '0 : min_ff[MIN_X];
            CIDX_SW_COUNT:   counter_in = stat_ff[SLOT_SW_COUNT];
            CIDX_SW_SUM:     counter_in = stat_ff[SLOT_SW_SUM];
            CIDX_COL_PAIRS:  counter_in = stat_ff[SLOT_COL_PAIRS];
            CIDX_COL_SUM:    counter_in = stat_ff[SLOT_COL_SUM];
            default:         counter_in = '0;
         endcase
      end
   end

   assign gap_in    = (s2_is_cmd && s2_ff.col_valid) ? s2_ff.gap : '0;
   assign switch_in = s2_is_cmd && s2_ff.dir_switch;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAT_NUM; i++) begin
            stat_ff[i] <= '0;
         end
         for (int i = 0; i < MIN_NUM; i++) begin
            min_ff[i] <= '1;
         end
      end else if (s2_fire) begin
         for (int i = 0; i < STAT_NUM; i++) begin
            stat_ff[i] <= stat_in[i];
         end
         for (int i = 0; i < MIN_NUM; i++) begin
            min_ff[i] <= min_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         counter_ff <= counter_in;
         class_ff   <= s2_is_cmd ? s2_ff.pair_class : CLS_NONE;
         gap_ff     <= gap_in;
         viol_ff    <= viol_in;
         switch_ff  <= switch_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_counter_value    = counter_ff;
   assign rsp_pair_class       = class_ff;
   assign rsp_column_gap       = gap_ff;
   assign rsp_timing_violation = viol_ff;
   assign rsp_direction_switch = switch_ff;

   // checks
   a_read_implies_column: assert property (@(posedge clock) disable iff (reset)
      have_read_ff |-> have_col_ff)
      else $error("read tracked without a column command");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with empty input stage");

   a_violation_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timing_violation |->
         (rsp_pair_class == CLS_SAME_GROUP) || (rsp_pair_class == CLS_OTHER_GROUP))
      else $error("violation flagged outside a bank group pair");

   a_counter_read_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_counter_value != '0) |->
         (rsp_pair_class == CLS_NONE) && !rsp_direction_switch && (rsp_column_gap == '0))
      else $error("counter read beat carries command results");

endmodule

### test/tb_dram_column_command_monitor_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// DRAM column command monitor testbench
// A short scripted run from reset is followed by random command streams under
// several tCCD settings. Request and response sides both idle at random, and
// every response beat is checked field by field against scripted values or an in-bench model of
// the counters, gap tracking and read pair classing.
// ---------------------------------------------------------------------------
module tb_dram_column_command_monitor_top
   import dccm_pkg::*;
();

   localparam logic [2:0] CMD_CODE_SPARE = 3'd7;
   localparam logic [4:0] CIDX_SPARE     = 5'd31;
   localparam int unsigned DUE_DEPTH     = 64;
   localparam int unsigned SCRIPT_DEPTH  = 32;

   typedef struct {
      logic               kind;
      logic [2:0]         cmd;
      logic [CYCLE_W-1:0] cyc;
      logic [2:0]         ch;
      logic [3:0]         grp;
      logic [4:0]         idx;
   } dram_cmd_type;

   typedef struct {
      logic [CYCLE_W-1:0] value;
      class_type          cls;
      logic [CYCLE_W-1:0] gap;
      logic               viol;
      logic               sw;
   } monitor_result_type;

   typedef struct {
      dram_cmd_type       beat;
      bit                 typed;
      logic [CYCLE_W-1:0] value;
   } script_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_type;
   logic [2:0]         req_command;
   logic [CYCLE_W-1:0] req_issue_cycle;
   logic [2:0]         req_pseudo_channel;
   logic [3:0]         req_bank_group;
   logic [4:0]         req_counter_index;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [CYCLE_W-1:0] rsp_counter_value;
   logic [1:0]         rsp_pair_class;
   logic [CYCLE_W-1:0] rsp_column_gap;
   logic               rsp_timing_violation;
   logic               rsp_direction_switch;
   logic               csr_write;
   logic               csr_index;
   logic [TCCD_W-1:0]  csr_data;

   // model state
   logic [TCCD_W-1:0]  tccd_short_lim;
   logic [TCCD_W-1:0]  tccd_long_lim;
   logic               seen_read;
   logic               seen_column;
   logic               column_was_read;
   logic [CYCLE_W-1:0] first_rd_cyc;
   logic [CYCLE_W-1:0] last_rd_cyc;
   logic [CYCLE_W-1:0] last_col_cyc;
   logic [2:0]         last_rd_ch;
   logic [3:0]         last_rd_grp;
   logic [CYCLE_W-1:0] tally [STAT_NUM];
   logic [CYCLE_W-1:0] gap_floor [MIN_NUM];

   monitor_result_type reports_due [DUE_DEPTH];
   int unsigned        due_wr = 0;
   int unsigned        due_rd = 0;
   script_row_type     script_rows [SCRIPT_DEPTH];
   int unsigned        script_count;
   int unsigned        fault_count = 0;
   bit                 calm;
   logic [CYCLE_W-1:0] clock_cursor;
   logic [2:0]         lane_ch;
   logic [3:0]         lane_grp;

   dram_column_command_monitor_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_command          (req_command),
      .req_issue_cycle      (req_issue_cycle),
      .req_pseudo_channel   (req_pseudo_channel),
      .req_bank_group       (req_bank_group),
      .req_counter_index    (req_counter_index),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_counter_value    (rsp_counter_value),
      .rsp_pair_class       (rsp_pair_class),
      .rsp_column_gap       (rsp_column_gap),
      .rsp_timing_violation (rsp_timing_violation),
      .rsp_direction_switch (rsp_direction_switch),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [CYCLE_W-1:0] floor_shown(input int unsigned which);
      return (gap_floor[which] == '1) ? '0 : gap_floor[which];
   endfunction

   function automatic logic [CYCLE_W-1:0] stat_value(input logic [4:0] idx);
      case (idx)
         CIDX_READS:      return tally[SLOT_RD];
         CIDX_WRITES:     return tally[SLOT_WR];
         CIDX_ACTIVATES:  return tally[SLOT_ACT];
         CIDX_PRECHARGES: return tally[SLOT_PRE];
         CIDX_REF_BANK:   return tally[SLOT_REFPB];
         CIDX_REF_ALL:    return tally[SLOT_REFAB];
         CIDX_FIRST_READ: return seen_read ? first_rd_cyc : '0;
         CIDX_LAST_READ:  return seen_read ? last_rd_cyc : '0;
         CIDX_WINDOW:     return seen_read ? last_rd_cyc - first_rd_cyc + 64'd1 : '0;
         CIDX_L_PAIRS:    return tally[SLOT_L_PAIRS];
         CIDX_L_SUM:      return tally[SLOT_L_SUM];
         CIDX_L_MIN:      return floor_shown(MIN_L);
         CIDX_L_VIOL:     return tally[SLOT_L_VIOL];
         CIDX_S_PAIRS:    return tally[SLOT_S_PAIRS];
         CIDX_S_SUM:      return tally[SLOT_S_SUM];
         CIDX_S_MIN:      return floor_shown(MIN_S);
         CIDX_S_VIOL:     return tally[SLOT_S_VIOL];
         CIDX_X_PAIRS:    return tally[SLOT_X_PAIRS];
         CIDX_X_SUM:      return tally[SLOT_X_SUM];
         CIDX_X_MIN:      return floor_shown(MIN_X);
         CIDX_SW_COUNT:   return tally[SLOT_SW_COUNT];
         CIDX_SW_SUM:     return tally[SLOT_SW_SUM];
         CIDX_COL_PAIRS:  return tally[SLOT_COL_PAIRS];
         CIDX_COL_SUM:    return tally[SLOT_COL_SUM];
         default:         return '0;
      endcase
   endfunction

   task automatic log_pair(input int unsigned which, input logic [CYCLE_W-1:0] gap);
      int unsigned base;
      base = which * 3 + SLOT_L_PAIRS;
      tally[base]     = tally[base] + 64'd1;
      tally[base + 1] = tally[base + 1] + gap;
      if (gap < gap_floor[which]) gap_floor[which] = gap;
   endtask

   task automatic track_command(input dram_cmd_type b, output monitor_result_type r);
      logic [CYCLE_W-1:0] gap;
      logic               is_rd;
      logic               is_wr;
      r.value = '0;
      r.cls   = CLS_NONE;
      r.gap   = '0;
      r.viol  = 1'b0;
      r.sw    = 1'b0;
      if (b.kind == REQ_COUNTER) begin
         r.value = stat_value(b.idx);
      end else begin
         if (b.cmd <= CMD_REFRESH_ALL) tally[int'(b.cmd)] = tally[int'(b.cmd)] + 64'd1;
         is_rd = (b.cmd == CMD_READ);
         is_wr = (b.cmd == CMD_WRITE);
         if (is_rd) begin
            if (!seen_read) first_rd_cyc = b.cyc;
            if (seen_read && seen_column && column_was_read) begin
               gap = b.cyc - last_rd_cyc;
               if (b.ch != last_rd_ch) begin
                  r.cls = CLS_CROSS_CHANNEL;
                  log_pair(MIN_X, gap);
               end else if (b.grp == last_rd_grp) begin
                  r.cls = CLS_SAME_GROUP;
                  log_pair(MIN_L, gap);
                  if (gap < {56'd0, tccd_long_lim}) begin
                     r.viol = 1'b1;
                     tally[SLOT_L_VIOL] = tally[SLOT_L_VIOL] + 64'd1;
                  end
               end else begin
                  r.cls = CLS_OTHER_GROUP;
                  log_pair(MIN_S, gap);
                  if (gap < {56'd0, tccd_short_lim}) begin
                     r.viol = 1'b1;
                     tally[SLOT_S_VIOL] = tally[SLOT_S_VIOL] + 64'd1;
                  end
               end
            end
            seen_read   = 1'b1;
            last_rd_cyc = b.cyc;
            last_rd_ch  = b.ch;
            last_rd_grp = b.grp;
         end
         if (is_rd || is_wr) begin
            if (seen_column) begin
               r.gap = b.cyc - last_col_cyc;
               tally[SLOT_COL_SUM]   = tally[SLOT_COL_SUM] + r.gap;
               tally[SLOT_COL_PAIRS] = tally[SLOT_COL_PAIRS] + 64'd1;
               if (column_was_read != is_rd) begin
                  r.sw = 1'b1;
                  tally[SLOT_SW_COUNT] = tally[SLOT_SW_COUNT] + 64'd1;
                  tally[SLOT_SW_SUM]   = tally[SLOT_SW_SUM] + r.gap;
               end
            end
            seen_column     = 1'b1;
            column_was_read = is_rd;
            last_col_cyc    = b.cyc;
         end
      end
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic issue_beat(input dram_cmd_type b, input bit typed,
                             input logic [CYCLE_W-1:0] typed_value);
      monitor_result_type r;
      while (!calm && $urandom_range(99) < 8) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid          = 1'b1;
      req_type           = b.kind;
      req_command        = b.cmd;
      req_issue_cycle    = b.cyc;
      req_pseudo_channel = b.ch;
      req_bank_group     = b.grp;
      req_counter_index  = b.idx;
      do @(posedge clock); while (req_stall);
      track_command(b, r);
      if (typed) begin
         r.value = typed_value;
         r.cls   = CLS_NONE;
         r.gap   = '0;
         r.viol  = 1'b0;
         r.sw    = 1'b0;
      end
      reports_due[due_wr % DUE_DEPTH] = r;
      due_wr++;
      @(negedge clock);
   endtask

   task automatic script(input logic kind, input logic [2:0] cmd,
                         input logic [CYCLE_W-1:0] cyc, input logic [2:0] ch,
                         input logic [3:0] grp, input logic [4:0] idx,
                         input bit typed, input logic [CYCLE_W-1:0] value);
      script_row_type row;
      row.beat.kind = kind;
      row.beat.cmd  = cmd;
      row.beat.cyc  = cyc;
      row.beat.ch   = ch;
      row.beat.grp  = grp;
      row.beat.idx  = idx;
      row.typed     = typed;
      row.value     = value;
      script_rows[script_count] = row;
      script_count++;
   endtask

   task automatic random_beat(output dram_cmd_type b);
      int unsigned pick;
      pick = $urandom_range(99);
      if ($urandom_range(19) == 0) clock_cursor = {$urandom, $urandom};
      else clock_cursor = clock_cursor + 64'($urandom_range(6));
      if ($urandom_range(9) < 2) lane_ch = 3'($urandom_range(7));
      if ($urandom_range(9) < 4) lane_grp = 4'($urandom_range(15));
      b.kind = REQ_COMMAND;
      b.cyc  = clock_cursor;
      b.ch   = lane_ch;
      b.grp  = lane_grp;
      b.idx  = 5'($urandom_range(31));
      if (pick < 15) begin
         b.kind = REQ_COUNTER;
         b.cmd  = 3'($urandom_range(7));
         b.cyc  = {$urandom, $urandom};
         b.ch   = 3'($urandom_range(7));
         b.grp  = 4'($urandom_range(15));
      end else if (pick < 27) begin
         b.cmd = 3'($urandom_range(7, 2));
      end else if ($urandom_range(9) < 7) begin
         b.cmd = CMD_READ;
      end else begin
         b.cmd = CMD_WRITE;
      end
   endtask

   task automatic drain_reports();
      req_valid = 1'b0;
      while (due_wr != due_rd) @(negedge clock);
   endtask

   task automatic program_tccd(input logic [TCCD_W-1:0] short_lim,
                               input logic [TCCD_W-1:0] long_lim);
      csr_write = 1'b1;
      csr_index = CSR_TCCD_SHORT;
      csr_data  = short_lim;
      @(negedge clock);
      tccd_short_lim = short_lim;
      csr_index = CSR_TCCD_LONG;
      csr_data  = long_lim;
      @(negedge clock);
      tccd_long_lim = long_lim;
      csr_write = 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_stall = !calm && ($urandom_range(99) < 8);
   end

   always @(posedge clock) begin
      monitor_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_wr == due_rd) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected response beat: value %h class %0d gap %h",
                        rsp_counter_value, rsp_pair_class, rsp_column_gap);
         end else begin
            e = reports_due[due_rd % DUE_DEPTH];
            due_rd++;
            if (rsp_counter_value !== e.value || rsp_pair_class !== e.cls ||
                rsp_column_gap !== e.gap || rsp_timing_violation !== e.viol ||
                rsp_direction_switch !== e.sw) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("mismatch: value exp %h got %h, class exp %0d got %0d",
                           e.value, rsp_counter_value, e.cls, rsp_pair_class);
                  $display("  gap exp %h got %h, viol exp %b got %b, switch exp %b got %b",
                           e.gap, rsp_column_gap, e.viol, rsp_timing_violation,
                           e.sw, rsp_direction_switch);
               end
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      dram_cmd_type      b;
      logic [TCCD_W-1:0] s_lim;
      logic [TCCD_W-1:0] l_lim;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_type           = REQ_COMMAND;
      req_command        = CMD_OTHER;
      req_issue_cycle    = '0;
      req_pseudo_channel = '0;
      req_bank_group     = '0;
      req_counter_index  = '0;
      csr_write          = 1'b0;
      csr_index          = CSR_TCCD_SHORT;
      csr_data           = '0;
      script_count       = 0;
      calm               = 1'b0;
      lane_ch            = '0;
      lane_grp           = '0;
      clock_cursor       = '0;
      tccd_short_lim     = TCCD_SHORT_RESET;
      tccd_long_lim      = TCCD_LONG_RESET;
      seen_read          = 1'b0;
      seen_column        = 1'b0;
      column_was_read    = 1'b0;
      first_rd_cyc       = '0;
      last_rd_cyc        = '0;
      last_col_cyc       = '0;
      last_rd_ch         = '0;
      last_rd_grp        = '0;
      foreach (tally[i]) tally[i] = '0;
      foreach (gap_floor[i]) gap_floor[i] = '1;

      // empty monitor, then a short read stream through every pair class
      script(REQ_COUNTER, CMD_READ,  '1,  3'd7, 4'd15, CIDX_READS,      1'b1, '0);
      script(REQ_COUNTER, CMD_WRITE, '0,  3'd0, 4'd0,  CIDX_L_MIN,      1'b1, '0);
      script(REQ_COUNTER, CMD_READ,  '0,  3'd0, 4'd0,  CIDX_FIRST_READ, 1'b1, '0);
      script(REQ_COUNTER, CMD_READ,  '0,  3'd0, 4'd0,  CIDX_WINDOW,     1'b1, '0);
      script(REQ_COUNTER, CMD_READ,  '0,  3'd0, 4'd0,  CIDX_SPARE,      1'b1, '0);
      script(REQ_COMMAND, CMD_WRITE, 64'd100, 3'd0, 4'd0,  CIDX_READS,  1'b1, '0);
      script(REQ_COMMAND, CMD_READ,  64'd103, 3'd0, 4'd0,  CIDX_READS,  1'b0, '0);
      script(REQ_COMMAND, CMD_READ,  64'd104, 3'd0, 4'd0,  CIDX_READS,  1'b0, '0);
      script(REQ_COMMAND, CMD_READ,  64'd106, 3'd0, 4'd1,  CIDX_READS,  1'b0, '0);
      script(REQ_COMMAND, CMD_READ,  64'd107, 3'd5, 4'd1,  CIDX_READS,  1'b0, '0);
      script(REQ_COMMAND, CMD_READ,  64'd108, 3'd5, 4'd15, CIDX_READS,  1'b0, '0);
      script(REQ_COMMAND, CMD_ACTIVATE,     64'd110, 3'd2, 4'd3, CIDX_SPARE, 1'b1, '0);
      script(REQ_COMMAND, CMD_PRECHARGE,    64'd111, 3'd2, 4'd3, CIDX_SPARE, 1'b1, '0);
      script(REQ_COMMAND, CMD_REFRESH_BANK, 64'd112, 3'd2, 4'd3, CIDX_SPARE, 1'b1, '0);
      script(REQ_COMMAND, CMD_REFRESH_ALL,  64'd113, 3'd2, 4'd3, CIDX_SPARE, 1'b1, '0);
      script(REQ_COMMAND, CMD_OTHER,        64'd114, 3'd2, 4'd3, CIDX_SPARE, 1'b1, '0);
      script(REQ_COMMAND, CMD_CODE_SPARE,   64'd115, 3'd2, 4'd3, CIDX_SPARE, 1'b1, '0);
      // cycle count wraps between these two
      script(REQ_COMMAND, CMD_READ,  '1,  3'd7, 4'd15, CIDX_READS,      1'b0, '0);
      script(REQ_COMMAND, CMD_READ,  '0,  3'd7, 4'd15, CIDX_READS,      1'b0, '0);
      script(REQ_COUNTER, CMD_READ,  '0,  3'd0, 4'd0,  CIDX_WINDOW,     1'b0, '0);
      script(REQ_COUNTER, CMD_READ,  '0,  3'd0, 4'd0,  CIDX_L_MIN,      1'b0, '0);
      script(REQ_COUNTER, CMD_READ,  '0,  3'd0, 4'd0,  CIDX_S_MIN,      1'b0, '0);
      script(REQ_COUNTER, CMD_READ,  '0,  3'd0, 4'd0,  CIDX_X_MIN,      1'b0, '0);
      script(REQ_COUNTER, CMD_READ,  '0,  3'd0, 4'd0,  CIDX_SW_SUM,     1'b0, '0);
      script(REQ_COUNTER, CMD_READ,  '0,  3'd0, 4'd0,  CIDX_COL_SUM,    1'b0, '0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int unsigned i = 0; i < script_count; i++)
         issue_beat(script_rows[i].beat, script_rows[i].typed, script_rows[i].value);

      for (int ph = 0; ph < 5; ph++) begin
         drain_reports();
         case (ph)
            0: begin s_lim = 8'd0;   l_lim = 8'd0;   end
            1: begin s_lim = 8'd255; l_lim = 8'd255; end
            2: begin s_lim = 8'($urandom_range(255)); l_lim = 8'($urandom_range(255)); end
            3: begin s_lim = 8'd1;   l_lim = 8'd7;   end
            default: begin s_lim = 8'd255; l_lim = 8'd0; end
         endcase
         program_tccd(s_lim, l_lim);
         clock_cursor = {$urandom, $urandom};
         for (int n = 0; n < 160; n++) begin
            // back to back run for the first 120 beats of phase 1, no idling on either side
            calm = (ph == 1 && n < 120);
            random_beat(b);
            issue_beat(b, 1'b0, '0);
         end
      end
      calm = 1'b0;
      drain_reports();
      repeat (10) @(posedge clock);
      if (fault_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
